>>> rtl/core/octree_box_cell_index_core_assert.svh
// assertion macros used by the port-level checker of the octree cell index core
// depends on nothing; each user provides clock and reset signals in scope
`ifndef OCTREE_BOX_CELL_INDEX_CORE_ASSERT_SVH
`define OCTREE_BOX_CELL_INDEX_CORE_ASSERT_SVH

// same-cycle implication
`define OBCI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obci assertion failed");

// implication after a fixed number of cycles
`define OBCI_ASSERT_DLY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("obci assertion failed");

`endif

>>> rtl/core/obci_pkg.sv
// shared constants, types and helper functions of the octree cell index core
// used by obci_axis, octree_box_cell_index_core, obci_checker, cell_index_checker and testbench
package obci_pkg;

   localparam int LEVELS    = 4;
   localparam int FRAC_BITS = 16;

   localparam int WORD_W   = 32;
   localparam int PROD_W   = 2 * WORD_W;
   localparam int SHIFT    = 2 * FRAC_BITS;
   localparam int PHI_W    = PROD_W - SHIFT;
   localparam int COORD_W  = LEVELS;
   localparam int CODE_W   = 3 * LEVELS;
   localparam int HI_W     = $clog2(LEVELS + 1);
   localparam int SH_W     = $clog2(3 * LEVELS + 1);
   localparam int NODE_W   = 10;
   localparam int LEVEL_W  = 2;
   localparam int CELL_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int DEPTH    = 5;

   localparam logic [COORD_W-1:0] COORD_TOP = {COORD_W{1'b1}};
   localparam logic [WORD_W-1:0]  INV_RESET = WORD_W'(1 << 16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_INV_UNIT_X = 3'd3,
      CSR_INV_UNIT_Y = 3'd4,
      CSR_INV_UNIT_Z = 3'd5
   } csr_index_type;

   // first node index of a tree level: (8^level - 1) / 7
   function automatic logic [NODE_W-1:0] level_start(input logic [HI_W-1:0] lvl);
      logic [NODE_W-1:0] acc;
      logic [NODE_W-1:0] pow;
      acc = '0;
      pow = NODE_W'(1);
      for (int i = 0; i < LEVELS; i++) begin
         if (HI_W'(i) < lvl) begin
            acc = acc + pow;
         end
         pow = pow << 3;
      end
      return acc;
   endfunction

endpackage

>>> rtl/core/obci_axis.sv
// one axis of one corner: origin offset, scale multiply, truncate and clamp
// three register stages; depends on obci_pkg
module obci_axis
   import obci_pkg::*;
(
   input  logic                clock,
   input  logic [WORD_W-1:0]   pos,
   input  logic [WORD_W-1:0]   org,
   input  logic [WORD_W-1:0]   inv,
   output logic [COORD_W-1:0]  coord
);

   logic [WORD_W:0]     diff_full;
   logic [WORD_W-1:0]   diff_ff;
   logic                above_ff;
   logic                above_in;
   logic [PROD_W-1:0]   prod;
   logic [PHI_W-1:0]    prod_hi_in;
   logic [PHI_W-1:0]    prod_hi_ff;
   logic [COORD_W-1:0]  cell_in;
   logic [COORD_W-1:0]  cell_ff;

   // stage 1: signed offset, positive test
   assign diff_full = {pos[WORD_W-1], pos} - {org[WORD_W-1], org};
   assign above_in  = !diff_full[WORD_W] && (diff_full != '0);

   always_ff @(posedge clock) begin
      diff_ff  <= diff_full[WORD_W-1:0];
      above_ff <= above_in;
   end

   // stage 2: scale
   assign prod       = PROD_W'(diff_ff) * PROD_W'(inv);
   assign prod_hi_in = above_ff ? prod[PROD_W-1:SHIFT] : '0;

   always_ff @(posedge clock) begin
      prod_hi_ff <= prod_hi_in;
   end

   // stage 3: clamp to grid
   assign cell_in = (prod_hi_ff > PHI_W'(COORD_TOP)) ? COORD_TOP
                                                     : prod_hi_ff[COORD_W-1:0];

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign coord = cell_ff;

endmodule

>>> rtl/core/octree_box_cell_index_core.sv
// top level of the octree box cell index core: csr bank, six axis pipes,
// morton level search and node index; depends on obci_pkg and obci_axis
//
// channel  ports                                   direction
// req      start, busy, req_box_min_*, req_box_max_*  in (busy out)
// rsp      rsp_valid, rsp_node_index, rsp_tree_level, rsp_cell_in_level  out
// csr      csr_valid, csr_ready, csr_index, csr_data  in (ready out)
//
// one word accepted per cycle while busy is low; its result moves down the
// valid pipe with its data and shows on the rsp ports with rsp_valid
// the data path is the axis pipe (offset, multiply, clamp) plus level search
// and index add stages; throughput one word per cycle while busy is low
// busy is reset registered: high in the cycle after each reset cycle; csr_ready is always high
// no stalls: results cannot be held off; reset clears the valid pipe
module octree_box_cell_index_core
   import obci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [WORD_W-1:0]     req_box_min_x,
   input  logic [WORD_W-1:0]     req_box_min_y,
   input  logic [WORD_W-1:0]     req_box_min_z,
   input  logic [WORD_W-1:0]     req_box_max_x,
   input  logic [WORD_W-1:0]     req_box_max_y,
   input  logic [WORD_W-1:0]     req_box_max_z,
   output logic                  rsp_valid,
   output logic [NODE_W-1:0]     rsp_node_index,
   output logic [LEVEL_W-1:0]    rsp_tree_level,
   output logic [CELL_W-1:0]     rsp_cell_in_level,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_data
);

   logic [WORD_W-1:0]   origin_x_ff, origin_y_ff, origin_z_ff;
   logic [WORD_W-1:0]   inv_x_ff, inv_y_ff, inv_z_ff;
   logic                busy_ff;
   logic [DEPTH-1:0]    vld_ff;
   logic [DEPTH-1:0]    vld_in;
   logic                accept;

   logic [COORD_W-1:0]  min_x, min_y, min_z, max_x, max_y, max_z;
   logic [CODE_W-1:0]   min_code, max_code, code_diff;
   logic [HI_W-1:0]     hi_in;
   logic [HI_W-1:0]     hi_ff;
   logic [CODE_W-1:0]   max_code_ff;

   logic [HI_W-1:0]     lvl;
   logic [SH_W-1:0]     sh;
   logic [CODE_W-1:0]   cell_full;
   logic [NODE_W-1:0]   node_in;
   logic [NODE_W-1:0]   node_ff;
   logic [LEVEL_W-1:0]  level_ff;
   logic [CELL_W-1:0]   cell_ff;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         inv_x_ff    <= INV_RESET;
         inv_y_ff    <= INV_RESET;
         inv_z_ff    <= INV_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:   origin_x_ff <= csr_data;
            CSR_ORIGIN_Y:   origin_y_ff <= csr_data;
            CSR_ORIGIN_Z:   origin_z_ff <= csr_data;
            CSR_INV_UNIT_X: inv_x_ff    <= csr_data;
            CSR_INV_UNIT_Y: inv_y_ff    <= csr_data;
            CSR_INV_UNIT_Z: inv_z_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // valid pipe
   assign vld_in = {vld_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   obci_axis u_min_x (.clock(clock), .pos(req_box_min_x), .org(origin_x_ff),
                      .inv(inv_x_ff), .coord(min_x));
   obci_axis u_min_y (.clock(clock), .pos(req_box_min_y), .org(origin_y_ff),
                      .inv(inv_y_ff), .coord(min_y));
   obci_axis u_min_z (.clock(clock), .pos(req_box_min_z), .org(origin_z_ff),
                      .inv(inv_z_ff), .coord(min_z));
   obci_axis u_max_x (.clock(clock), .pos(req_box_max_x), .org(origin_x_ff),
                      .inv(inv_x_ff), .coord(max_x));
   obci_axis u_max_y (.clock(clock), .pos(req_box_max_y), .org(origin_y_ff),
                      .inv(inv_y_ff), .coord(max_y));
   obci_axis u_max_z (.clock(clock), .pos(req_box_max_z), .org(origin_z_ff),
                      .inv(inv_z_ff), .coord(max_z));

   // stage 4: morton interleave and highest differing group
   always_comb begin
      min_code = '0;
      max_code = '0;
      for (int i = 0; i < LEVELS; i++) begin
         min_code[3*i]     = min_x[i];
         min_code[3*i + 1] = min_y[i];
         min_code[3*i + 2] = min_z[i];
         max_code[3*i]     = max_x[i];
         max_code[3*i + 1] = max_y[i];
         max_code[3*i + 2] = max_z[i];
      end
   end

   assign code_diff = min_code ^ max_code;

   always_comb begin
      hi_in = HI_W'(1);
      for (int i = 0; i < LEVELS; i++) begin
         if (code_diff[3*i +: 3] != 3'd0) begin
            hi_in = HI_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      max_code_ff <= max_code;
   end

   // stage 5: level, cell within level, linear node index
   assign lvl       = HI_W'(LEVELS) - hi_ff;
   assign sh        = SH_W'(hi_ff) * SH_W'(3);
   assign cell_full = max_code_ff >> sh;
   assign node_in   = level_start(lvl) + NODE_W'(cell_full);

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      level_ff <= LEVEL_W'(lvl);
      cell_ff  <= CELL_W'(cell_full);
   end

   assign rsp_valid         = vld_ff[DEPTH-1];
   assign rsp_node_index    = node_ff;
   assign rsp_tree_level    = level_ff;
   assign rsp_cell_in_level = cell_ff;

endmodule

>>> rtl/core/obci_checker.sv
// port-level checker of the octree box cell index core and its bind
// depends on obci_pkg and octree_box_cell_index_core_assert.svh
`include "octree_box_cell_index_core_assert.svh"

module obci_checker
   import obci_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                rsp_valid,
   input  logic [NODE_W-1:0]   rsp_node_index,
   input  logic [LEVEL_W-1:0]  rsp_tree_level,
   input  logic [CELL_W-1:0]   rsp_cell_in_level
);

   logic               at_root;
   logic               at_leaf;
   logic [NODE_W-1:0]  leaf_node;

   assign at_root   = rsp_valid && rsp_tree_level == 2'd0;
   assign at_leaf   = rsp_valid && rsp_tree_level == 2'd3;
   assign leaf_node = NODE_W'(rsp_cell_in_level) + 10'd73;

   // one word out per word in, fixed latency
   `OBCI_ASSERT_DLY(a_word_out, start && !busy, 5, rsp_valid)
   `OBCI_ASSERT_DLY(a_no_extra, !(start && !busy), 5, !rsp_valid)
   // root holds only cell zero
   `OBCI_ASSERT_IMP(a_root, at_root, rsp_node_index == '0 && rsp_cell_in_level == '0)
   // deepest level starts at node 73
   `OBCI_ASSERT_IMP(a_leaf, at_leaf, rsp_node_index == leaf_node)

endmodule

bind octree_box_cell_index_core obci_checker u_obci_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_node_index    (rsp_node_index),
   .rsp_tree_level    (rsp_tree_level),
   .rsp_cell_in_level (rsp_cell_in_level)
);

>>> sim/cell_index_checker.sv
`timescale 1ns / 100ps
// watches the request, result and csr channels of the octree cell index core,
// predicts each node index, level and cell and compares them; depends on obci_pkg
module cell_index_checker
   import obci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [WORD_W-1:0]     req_box_min_x,
   input  logic [WORD_W-1:0]     req_box_min_y,
   input  logic [WORD_W-1:0]     req_box_min_z,
   input  logic [WORD_W-1:0]     req_box_max_x,
   input  logic [WORD_W-1:0]     req_box_max_y,
   input  logic [WORD_W-1:0]     req_box_max_z,
   input  logic                  rsp_valid,
   input  logic [NODE_W-1:0]     rsp_node_index,
   input  logic [LEVEL_W-1:0]    rsp_tree_level,
   input  logic [CELL_W-1:0]     rsp_cell_in_level,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_data,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [LEVEL_W-1:0] level;
      logic [CELL_W-1:0]  cell_num;
   } node_place_type;

   node_place_type    expected_nodes[$];
   logic [WORD_W-1:0] origin[3];
   logic [WORD_W-1:0] inv_unit[3];
   int                failures = 0;

   // clamped grid coordinate of one corner along one axis
   function automatic logic [COORD_W-1:0] grid_coord(input logic [WORD_W-1:0] pos,
                                                    input logic [WORD_W-1:0] org,
                                                    input logic [WORD_W-1:0] inv);
      longint          offset;
      longint unsigned scaled;
      offset = longint'($signed(pos)) - longint'($signed(org));
      if (offset <= 0) begin
         return '0;
      end
      scaled = (longint'(offset) * longint'({32'd0, inv})) >> SHIFT;
      if (scaled > longint'(COORD_TOP)) begin
         return COORD_TOP;
      end
      return scaled[COORD_W-1:0];
   endfunction

   function automatic logic [CODE_W-1:0] morton(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z);
      logic [CODE_W-1:0] code;
      code = '0;
      for (int i = 0; i < LEVELS; i++) begin
         code[3*i]   = x[i];
         code[3*i+1] = y[i];
         code[3*i+2] = z[i];
      end
      return code;
   endfunction

   function automatic node_place_type locate_box(input logic [WORD_W-1:0] mnx, mny, mnz,
                                                 input logic [WORD_W-1:0] mxx, mxy, mxz);
      logic [CODE_W-1:0] lo_code;
      logic [CODE_W-1:0] hi_code;
      logic [CODE_W-1:0] differ;
      int                top_group;
      int                depth;
      int                cell_num;
      int                first_node;
      int                stride;
      node_place_type    place;
      lo_code = morton(grid_coord(mnx, origin[0], inv_unit[0]),
                       grid_coord(mny, origin[1], inv_unit[1]),
                       grid_coord(mnz, origin[2], inv_unit[2]));
      hi_code = morton(grid_coord(mxx, origin[0], inv_unit[0]),
                       grid_coord(mxy, origin[1], inv_unit[1]),
                       grid_coord(mxz, origin[2], inv_unit[2]));
      differ = lo_code ^ hi_code;
      top_group = 1;
      for (int i = 0; i < LEVELS; i++) begin
         if (differ[3*i +: 3] != 3'b000) begin
            top_group = i + 1;
         end
      end
      depth = LEVELS - top_group;
      cell_num = int'(hi_code >> (3 * top_group));
      first_node = 0;
      stride = 1;
      for (int i = 0; i < depth; i++) begin
         first_node += stride;
         stride *= 8;
      end
      place.node     = NODE_W'(first_node + cell_num);
      place.level    = LEVEL_W'(depth);
      place.cell_num = CELL_W'(cell_num);
      return place;
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endfunction

   always @(posedge clock) begin
      node_place_type want;
      node_place_type fresh;
      if (reset) begin
         origin = '{3{'0}};
         inv_unit = '{3{INV_RESET}};
         expected_nodes.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_nodes.size() == 0) begin
               note_failure($sformatf("extra result word: node %0d level %0d cell %0d",
                                      rsp_node_index, rsp_tree_level, rsp_cell_in_level));
            end else begin
               want = expected_nodes.pop_front();
               if (rsp_node_index !== want.node || rsp_tree_level !== want.level ||
                   rsp_cell_in_level !== want.cell_num) begin
                  note_failure($sformatf("node/level/cell expected %0d/%0d/%0d got %0d/%0d/%0d",
                                         want.node, want.level, want.cell_num,
                                         rsp_node_index, rsp_tree_level,
                                         rsp_cell_in_level));
               end
            end
         end
         if (start && !busy) begin
            fresh = locate_box(req_box_min_x, req_box_min_y, req_box_min_z,
                               req_box_max_x, req_box_max_y, req_box_max_z);
            expected_nodes = {expected_nodes, fresh};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:   origin[0] = csr_data;
               CSR_ORIGIN_Y:   origin[1] = csr_data;
               CSR_ORIGIN_Z:   origin[2] = csr_data;
               CSR_INV_UNIT_X: inv_unit[0] = csr_data;
               CSR_INV_UNIT_Y: inv_unit[1] = csr_data;
               CSR_INV_UNIT_Z: inv_unit[2] = csr_data;
               default: ;
            endcase
         end
      end
      mismatches <= failures;
      outstanding <= expected_nodes.size();
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// top of the octree cell index testbench: clock, reset, box and csr stimulus
// and the verdict; depends on obci_pkg, cell_index_checker and the core
module testbench;
   import obci_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [WORD_W-1:0] UNIT = 32'h0001_0000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [WORD_W-1:0]    req_box_min_x, req_box_min_y, req_box_min_z;
   logic [WORD_W-1:0]    req_box_max_x, req_box_max_y, req_box_max_z;
   logic                 rsp_valid;
   logic [NODE_W-1:0]    rsp_node_index;
   logic [LEVEL_W-1:0]   rsp_tree_level;
   logic [CELL_W-1:0]    rsp_cell_in_level;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;
   int                   mismatches;
   int                   outstanding;
   int                   cycle_count = 0;

   octree_box_cell_index_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z), .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y), .req_box_max_z(req_box_max_z),
      .rsp_valid(rsp_valid), .rsp_node_index(rsp_node_index),
      .rsp_tree_level(rsp_tree_level), .rsp_cell_in_level(rsp_cell_in_level),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   cell_index_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z), .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y), .req_box_max_z(req_box_max_z),
      .rsp_valid(rsp_valid), .rsp_node_index(rsp_node_index),
      .rsp_tree_level(rsp_tree_level), .rsp_cell_in_level(rsp_cell_in_level),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic drive_box(input logic [WORD_W-1:0] mnx, mny, mnz, mxx, mxy, mxz);
      start <= 1'b1;
      req_box_min_x <= mnx;
      req_box_min_y <= mny;
      req_box_min_z <= mnz;
      req_box_max_x <= mxx;
      req_box_max_y <= mxy;
      req_box_max_z <= mxz;
      do @(posedge clock); while (busy);
   endtask

   // stop issuing and let every outstanding word come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_config(input logic [WORD_W-1:0] ox, oy, oz, ix, iy, iz);
      logic [WORD_W-1:0] vals[6];
      csr_index_type     idx;
      vals = '{ox, oy, oz, ix, iy, iz};
      idx = CSR_ORIGIN_X;
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] grid_point();
      return $urandom_range(0, 24 << 16) - (4 << 16);
   endfunction

   task automatic random_box();
      logic [WORD_W-1:0] lo[3];
      logic [WORD_W-1:0] hi[3];
      logic [WORD_W-1:0] swap;
      if ($urandom_range(0, 7) == 0) begin
         for (int a = 0; a < 3; a++) begin
            lo[a] = $urandom;
            hi[a] = $urandom;
         end
      end else begin
         for (int a = 0; a < 3; a++) begin
            lo[a] = grid_point();
            hi[a] = lo[a] + $urandom_range(0, 1 << $urandom_range(0, 21));
            if ($urandom_range(0, 15) == 0) begin
               swap = lo[a];
               lo[a] = hi[a];
               hi[a] = swap;
            end
         end
      end
      drive_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   task automatic random_boxes(input int count, input bit gaps);
      for (int n = 0; n < count; n++) begin
         if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         random_box();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_box_min_x = '0;
      req_box_min_y = '0;
      req_box_min_z = '0;
      req_box_max_x = '0;
      req_box_max_y = '0;
      req_box_max_z = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ORIGIN_X;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed boxes at the reset grid, one cell per unit
      drive_box('0, '0, '0, '0, '0, '0);
      drive_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drive_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drive_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_box('0, '0, '0, UNIT + UNIT / 2, '0, '0);
      drive_box('0, '0, '0, 2 * UNIT, '0, '0);
      drive_box('0, '0, '0, '0, 4 * UNIT, '0);
      drive_box('0, '0, '0, '0, '0, 8 * UNIT);
      drive_box(9 * UNIT, 9 * UNIT, 9 * UNIT, UNIT, UNIT, UNIT);
      drive_box(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
                32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF);
      drive_box(-3 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT);
      drive_box(15 * UNIT, 15 * UNIT, 15 * UNIT, 100 * UNIT, 15 * UNIT, 15 * UNIT);
      drive_box(5 * UNIT, 6 * UNIT, 7 * UNIT, 5 * UNIT, 6 * UNIT, 7 * UNIT);
      random_boxes(110, 1'b1);
      drain();

      // coarse x, fine z, shifted origin
      load_config(32'hFFF8_0000, 32'h0000_0000, 32'h0002_0000,
                  32'h0000_8000, 32'h0001_0000, 32'h0002_0000);
      random_boxes(170, 1'b1);
      drain();

      // zero reciprocal
      load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, '0, '0, '0);
      drive_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_boxes(40, 1'b1);
      drain();

      // lowest origin, largest reciprocal: nearly everything saturates
      load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      drive_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
      random_boxes(60, 1'b1);
      drain();

      // highest origin, smallest nonzero reciprocal
      load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      drive_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_boxes(40, 1'b1);
      drain();

      // random origin and scale
      load_config($urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(32'h0000_4000, 32'h0004_0000),
                  $urandom_range(32'h0000_4000, 32'h0004_0000),
                  $urandom_range(32'h0000_4000, 32'h0004_0000));
      random_boxes(200, 1'b1);
      drain();

      // back to reset values, streaming with no gaps
      load_config('0, '0, '0, INV_RESET, INV_RESET, INV_RESET);
      random_boxes(200, 1'b0);
      drain();

      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
